[rtl/spl_pkg.sv]
// spl_pkg: shared widths, register codes and constants of the stereo pan law unit
// also holds the elaboration-time sine generator for the gain rom
// no dependencies
package spl_pkg;

  localparam int SAMPLE_W = 24;
  localparam int PAN_W    = 17;
  localparam int KNOB_W   = 17;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_KNOB_PAN       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_POWER = 1'd1;

  localparam logic [KNOB_W-1:0] KNOB_RESET = 17'd32768;
  localparam logic [PAN_W-1:0]  PAN_ONE    = 17'd65536;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int GAIN_FRAC_BITS_DEF   = 16;

  // +-5 V at 2^-19 V per lsb
  localparam logic signed [SAMPLE_W-1:0] MOD_LIMIT = 24'sd2621440;

  // (v + 5 V) / 80 is done as (x >> 4) / 5, the /5 as a reciprocal multiply
  // exact for quotients of inputs up to 699050, the range here is 0..327680
  localparam int MOD_Q_W = 19;
  localparam logic [MOD_Q_W-1:0] DIV5_MUL = 19'd419431;
  localparam int DIV5_SHIFT = 21;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 12;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

  // sin of a q30 angle in [0, pi/2], rounded to q0.frac and clamped to [0, 1]
  function automatic longint unsigned sine_gain(longint unsigned x, int unsigned frac);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          full;
    int unsigned     drop;
    drop = 30 - frac;
    full = longint'(1) << frac;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + (longint'(1) << (drop - 1))) >>> drop;
    if (sum > full) begin
      sum = full;
    end
    return unsigned'(sum);
  endfunction

endpackage

[rtl/spl_stream_if.sv]
// spl_stream_if: valid/ready stream interfaces of the stereo pan law unit
// spl_in_if carries mono words, spl_out_if carries stereo words; uses spl_pkg
interface spl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [spl_pkg::SAMPLE_W-1:0]   sample_in;
  logic                                  mod_present;
  logic signed [spl_pkg::SAMPLE_W-1:0]   mod_voltage;

  modport source (output valid, output sample_in, output mod_present, output mod_voltage,
                  input ready);
  modport sink (input valid, input sample_in, input mod_present, input mod_voltage,
                output ready);
endinterface

interface spl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [spl_pkg::SAMPLE_W-1:0]   left_out;
  logic signed [spl_pkg::SAMPLE_W-1:0]   right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

[rtl/spl_sine_rom.sv]
// spl_sine_rom: quarter-wave sine gain rom with two registered read ports
// contents are generated at elaboration from spl_pkg::sine_gain
module spl_sine_rom #(
  parameter int SINE_TABLE_DEPTH = spl_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int GAIN_FRAC_BITS   = spl_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_a,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_b,
  output logic [GAIN_FRAC_BITS:0]               data_a,
  output logic [GAIN_FRAC_BITS:0]               data_b
);

  localparam int GW = GAIN_FRAC_BITS + 1;

  logic [GW-1:0] rom [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    // angle k * (pi/2) / depth in q30, rounded down
    localparam longint unsigned ANGLE =
      (64'(k) * spl_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign rom[k] = GW'(spl_pkg::sine_gain(ANGLE, GAIN_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

[rtl/stereo_pan_law_unit.sv]
// stereo_pan_law_unit: four-stage pipelined linear / constant-power stereo panner
// uses spl_pkg, spl_in_if, spl_out_if and spl_sine_rom
//
// din carries one mono word (sample_in, mod_present, mod_voltage); dout carries
// the matching stereo word (left_out, right_out). Both are valid/ready streams,
// a word moves at a rising edge with valid and ready high.
// The pan comes from knob_pan (cfg index 0, saturated at 65536) or, when
// mod_present is set, from mod_voltage clamped to +-5 V and mapped to 0..1.
// constant_power (cfg index 1) picks sin/cos gains from the quarter-wave rom
// instead of the linear 1-pan / pan gains. Config is written through
// cfg_wr_en / cfg_index / cfg_wdata; the user must write it only while no word
// is in flight, the block itself does not enforce this. Four register stages:
// clamp, pan, gain lookup, multiply into the output register.
// Throughput: one word per cycle unless dout stalls; each stage holds one word
// and moves when the stage after it is empty or moving, so din.ready stays high
// while any stage has a bubble, also while a finished word waits on dout.
// When dout stalls the pipe fills up and then drops din.ready; nothing is lost.
// rst (synchronous) empties the pipe and sets knob_pan to 32768, linear law.
module stereo_pan_law_unit #(
  parameter int SINE_TABLE_DEPTH = spl_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int GAIN_FRAC_BITS   = spl_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  spl_in_if.sink                            din,
  spl_out_if.source                         dout,
  input  logic                              cfg_wr_en,
  input  logic [spl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SW  = spl_pkg::SAMPLE_W;
  localparam int GW  = GAIN_FRAC_BITS + 1;
  localparam int KW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QW  = spl_pkg::MOD_Q_W;
  localparam int UP  = (GAIN_FRAC_BITS >= 16) ? GAIN_FRAC_BITS - 16 : 0;
  localparam int DN  = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;
  localparam int LW  = spl_pkg::PAN_W + UP;
  localparam int PW  = SW + GW + 1;
  localparam logic [GW-1:0] FULL_GAIN = GW'(1) << GAIN_FRAC_BITS;

  // configuration
  logic [spl_pkg::KNOB_W-1:0] knob_pan;
  logic                       constant_power;

  always_ff @(posedge clk) begin
    if (rst) begin
      knob_pan       <= spl_pkg::KNOB_RESET;
      constant_power <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        spl_pkg::REG_KNOB_PAN:       knob_pan <= cfg_wdata[spl_pkg::KNOB_W-1:0];
        spl_pkg::REG_CONSTANT_POWER: constant_power <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = ~v4 | dout.ready;
  assign en3 = ~v3 | en4;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;
  assign din.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= din.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: clamp the mod voltage, offset to 0..10 V, drop 4 bits
  logic signed [SW-1:0] mod_clamped;
  logic signed [SW-1:0] mod_offset;
  logic signed [SW-1:0] sample1;
  logic                 mod_present1;
  logic [QW-1:0]        mod_q1;

  always_comb begin
    if (din.mod_voltage < -spl_pkg::MOD_LIMIT) begin
      mod_clamped = -spl_pkg::MOD_LIMIT;
    end else if (din.mod_voltage > spl_pkg::MOD_LIMIT) begin
      mod_clamped = spl_pkg::MOD_LIMIT;
    end else begin
      mod_clamped = din.mod_voltage;
    end
    mod_offset = mod_clamped + spl_pkg::MOD_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sample1      <= din.sample_in;
      mod_present1 <= din.mod_present;
      mod_q1       <= mod_offset[QW+3:4];
    end
  end

  // stage 2: pan from mod (divide by 5 via reciprocal) or saturated knob
  logic [2*QW-1:0]             div_prod;
  logic [spl_pkg::PAN_W-1:0]   pan_next;
  logic [spl_pkg::PAN_W-1:0]   pan2;
  logic signed [SW-1:0]        sample2;

  always_comb begin
    div_prod = (2*QW)'(mod_q1) * (2*QW)'(spl_pkg::DIV5_MUL);
    if (mod_present1) begin
      pan_next = div_prod[spl_pkg::DIV5_SHIFT +: spl_pkg::PAN_W];
    end else if (knob_pan > spl_pkg::PAN_ONE) begin
      pan_next = spl_pkg::PAN_ONE;
    end else begin
      pan_next = knob_pan;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pan2    <= pan_next;
      sample2 <= sample1;
    end
  end

  // stage 3: rom lookup and linear gains
  logic [spl_pkg::PAN_W+KW-1:0] k_prod;
  logic [KW-1:0]                k_right;
  logic [KW-1:0]                k_left;
  logic [LW-1:0]                lin_scaled;
  logic [GW-1:0]                gr_lin_next;
  logic [GW-1:0]                gr3_lin, gl3_lin;
  logic [GW-1:0]                gr3_rom, gl3_rom;
  logic signed [SW-1:0]         sample3;

  always_comb begin
    k_prod      = (spl_pkg::PAN_W+KW)'(pan2) * (spl_pkg::PAN_W+KW)'(SINE_TABLE_DEPTH);
    k_right     = KW'(k_prod >> 16);
    k_left      = KW'(SINE_TABLE_DEPTH) - k_right;
    lin_scaled  = (LW'(pan2) << UP) >> DN;
    gr_lin_next = GW'(lin_scaled);
  end

  spl_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (en3),
    .addr_a (k_right),
    .addr_b (k_left),
    .data_a (gr3_rom),
    .data_b (gl3_rom)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      gr3_lin <= gr_lin_next;
      gl3_lin <= FULL_GAIN - gr_lin_next;
      sample3 <= sample2;
    end
  end

  // stage 4: multiply, floor by dropping the fraction bits
  logic [GW-1:0]        gl_sel, gr_sel;
  logic signed [PW-1:0] prod_l, prod_r;
  logic signed [SW-1:0] left_reg, right_reg;

  always_comb begin
    gl_sel = constant_power ? gl3_rom : gl3_lin;
    gr_sel = constant_power ? gr3_rom : gr3_lin;
    prod_l = PW'(sample3) * PW'($signed({1'b0, gl_sel}));
    prod_r = PW'(sample3) * PW'($signed({1'b0, gr_sel}));
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      left_reg  <= prod_l[GAIN_FRAC_BITS +: SW];
      right_reg <= prod_r[GAIN_FRAC_BITS +: SW];
    end
  end

  assign dout.valid     = v4;
  assign dout.left_out  = left_reg;
  assign dout.right_out = right_reg;

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> v1)
    else $error("accepted word did not enter stage 1");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> (v1 && v2 && v3 && v4 && !dout.ready))
    else $error("input stalled while the pipe has a bubble");

  a_pan_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> pan2 <= spl_pkg::PAN_ONE)
    else $error("pan above full right");

  a_linear_sum: assert property (@(posedge clk) disable iff (rst)
    v3 |-> ((GW+1)'(gl3_lin) + (GW+1)'(gr3_lin)) == (GW+1)'(FULL_GAIN))
    else $error("linear gains do not sum to one");

endmodule

[tb/sv/spl_pan_checker.sv]
// spl_pan_checker: watches the mono and stereo streams of the stereo pan law unit,
// predicts each stereo word from its mono word and the current law, and counts mismatches
// uses spl_pkg, spl_in_if and spl_out_if
module spl_pan_checker import spl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  spl_in_if                     din,
  spl_out_if                    dout,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fails,
  output int                    pending
);

  localparam int ROM_DEPTH = SINE_TABLE_DEPTH_DEF;
  localparam int GAIN_FRAC = GAIN_FRAC_BITS_DEF;
  localparam int ROUND_DROP = 30 - GAIN_FRAC;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_s;
    logic signed [SAMPLE_W-1:0] right_s;
  } stereo_t;

  logic [GAIN_FRAC:0]   quarter_sine [0:ROM_DEPTH];
  logic [KNOB_W-1:0]    knob_cfg;
  logic                 sine_law;
  stereo_t              stereo_q [$];
  int                   err_cnt;

  assign fails = err_cnt;

  // quarter-wave sine in q0.16, q30 taylor series with every product floored
  initial begin
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint          acc;
    err_cnt = 0;
    pending = 0;
    for (int k = 0; k <= ROM_DEPTH; k++) begin
      ang  = (unsigned'(64'(k)) * HALF_PI_Q30) / unsigned'(64'(ROM_DEPTH));
      ang2 = (ang * ang) >> 30;
      term = ang;
      acc  = longint'(ang);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * ang2) >> 30) / unsigned'(64'((2 * n) * (2 * n + 1)));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + (longint'(1) << (ROUND_DROP - 1))) >>> ROUND_DROP;
      if (acc > (longint'(1) << GAIN_FRAC)) begin
        acc = longint'(1) << GAIN_FRAC;
      end
      quarter_sine[k] = acc[GAIN_FRAC:0];
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] apply_gain(
      input logic signed [SAMPLE_W-1:0] smp, input longint gain);
    longint prod;
    prod = longint'(smp) * gain;
    prod = prod >>> GAIN_FRAC;
    return prod[SAMPLE_W-1:0];
  endfunction

  function automatic stereo_t pan_split(input logic signed [SAMPLE_W-1:0] smp,
                                        input logic mod_on,
                                        input logic signed [SAMPLE_W-1:0] mod_v);
    longint  volts;
    longint  pan;
    longint  g_left;
    longint  g_right;
    int      idx;
    stereo_t res;
    if (mod_on) begin
      volts = longint'(mod_v);
      if (volts < -longint'(MOD_LIMIT)) begin
        volts = -longint'(MOD_LIMIT);
      end
      if (volts > longint'(MOD_LIMIT)) begin
        volts = longint'(MOD_LIMIT);
      end
      pan = (volts + longint'(MOD_LIMIT)) / 80;
    end else begin
      pan = (knob_cfg > PAN_ONE) ? longint'(PAN_ONE) : longint'(knob_cfg);
    end
    if (sine_law) begin
      idx = int'((pan * ROM_DEPTH) >> 16);
      if (idx > ROM_DEPTH) begin
        idx = ROM_DEPTH;
      end
      g_right = longint'(quarter_sine[idx]);
      g_left  = longint'(quarter_sine[ROM_DEPTH - idx]);
    end else begin
      g_right = pan;
      g_left  = (longint'(1) << GAIN_FRAC) - pan;
    end
    res.left_s  = apply_gain(smp, g_left);
    res.right_s = apply_gain(smp, g_right);
    return res;
  endfunction

  always @(posedge clk) begin
    stereo_t want;
    if (rst) begin
      knob_cfg = KNOB_RESET;
      sine_law = 1'b0;
      stereo_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_KNOB_PAN) begin
          knob_cfg = cfg_wdata[KNOB_W-1:0];
        end else if (cfg_index == REG_CONSTANT_POWER) begin
          sine_law = cfg_wdata[0];
        end
      end
      if (dout.valid && dout.ready) begin
        if (stereo_q.size() == 0) begin
          $display("%0t unexpected stereo word: left %0d right %0d",
                   $time, dout.left_out, dout.right_out);
          err_cnt++;
        end else begin
          want = stereo_q.pop_front();
          if (dout.left_out !== want.left_s) begin
            $display("%0t left_out mismatch: expected %0d, got %0d",
                     $time, want.left_s, dout.left_out);
            err_cnt++;
          end
          if (dout.right_out !== want.right_s) begin
            $display("%0t right_out mismatch: expected %0d, got %0d",
                     $time, want.right_s, dout.right_out);
            err_cnt++;
          end
        end
      end
      if (din.valid && din.ready) begin
        stereo_q.push_back(pan_split(din.sample_in, din.mod_present, din.mod_voltage));
      end
    end
    pending <= stereo_q.size();
  end

endmodule

[tb/sv/stereo_pan_law_unit_tb.sv]
// stereo_pan_law_unit_tb: drives mono words and law settings into the stereo pan law unit,
// stalls the stereo side at random and reports the verdict of spl_pan_checker
// uses spl_pkg, spl_in_if, spl_out_if, spl_pan_checker and stereo_pan_law_unit
module stereo_pan_law_unit_tb import spl_pkg::*; ;

  localparam logic [CFG_DATA_W-1:0] LAW_LINEAR = '0;
  localparam logic [CFG_DATA_W-1:0] LAW_SINE   = 17'd1;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  steady;
  int                    fails;
  int                    pending;

  spl_in_if  din_ch ();
  spl_out_if dout_ch ();

  stereo_pan_law_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .din       (din_ch),
    .dout      (dout_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  spl_pan_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .din       (din_ch),
    .dout      (dout_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    dout_ch.ready <= steady || ($urandom_range(0, 99) >= 13);
  end

  initial begin
    #2000000;
    $display("stereo_pan_law_unit regression: fail");
    $finish;
  end

  task automatic send_mono(input logic signed [SAMPLE_W-1:0] smp, input logic mod_on,
                           input logic signed [SAMPLE_W-1:0] mod_v);
    while (!steady && $urandom_range(0, 99) < 13) begin
      din_ch.valid <= 1'b0;
      @(posedge clk);
    end
    din_ch.valid       <= 1'b1;
    din_ch.sample_in   <= smp;
    din_ch.mod_present <= mod_on;
    din_ch.mod_voltage <= mod_v;
    @(posedge clk);
    while (!din_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // let the pipe run dry before touching the law registers
  task automatic drain();
    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_law(input logic [CFG_DATA_W-1:0] knob,
                           input logic [CFG_DATA_W-1:0] law);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_KNOB_PAN;
    cfg_wdata <= knob;
    @(posedge clk);
    cfg_index <= REG_CONSTANT_POWER;
    cfg_wdata <= law;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0]      knob_v;
    logic [CFG_DATA_W-1:0]      law_v;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [SAMPLE_W-1:0] mod_v;
    logic                       mod_on;
    rst                = 1'b1;
    steady             = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    din_ch.valid       = 1'b0;
    din_ch.sample_in   = '0;
    din_ch.mod_present = 1'b0;
    din_ch.mod_voltage = '0;
    dout_ch.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset law: linear, knob centered; modulation clamps and end points
    send_mono(S_MAX, 1'b0, '0);
    send_mono(S_MIN, 1'b0, '0);
    send_mono('0, 1'b0, '0);
    send_mono(S_MAX, 1'b1, S_MIN);
    send_mono(S_MAX, 1'b1, S_MAX);
    send_mono(S_MIN, 1'b1, -MOD_LIMIT);
    send_mono(S_MIN, 1'b1, MOD_LIMIT);
    send_mono(S_MAX, 1'b1, '0);
    send_mono(-24'sd1, 1'b1, 24'sd79);

    write_law(PAN_ONE, LAW_SINE);
    send_mono(S_MAX, 1'b0, '0);
    send_mono(S_MIN, 1'b0, '0);
    send_mono(S_MAX, 1'b1, -MOD_LIMIT);
    send_mono(S_MIN, 1'b1, MOD_LIMIT - 24'sd1);

    write_law('0, LAW_SINE);
    send_mono(S_MAX, 1'b0, '0);
    send_mono(S_MIN, 1'b0, '0);

    // knob beyond full right saturates; law word with junk above bit 0
    write_law(17'h1FFFF, 17'h1FFFE);
    send_mono(S_MAX, 1'b0, '0);
    send_mono(S_MIN, 1'b0, '0);

    write_law(17'h10001, 17'h10001);
    send_mono(S_MAX, 1'b0, '0);
    send_mono(S_MIN, 1'b0, '0);

    write_law('0, LAW_LINEAR);
    send_mono(S_MAX, 1'b0, '0);
    send_mono(S_MIN, 1'b0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(0, 4))
        3: knob_v = CFG_DATA_W'($urandom_range(65537, 131071));
        4: knob_v = $urandom_range(0, 1) ? PAN_ONE : '0;
        default: knob_v = CFG_DATA_W'($urandom_range(0, 65536));
      endcase
      law_v    = CFG_DATA_W'($urandom());
      law_v[0] = ph[0];
      write_law(knob_v, law_v);
      steady <= (ph == 2);
      for (int n = 0; n < 175; n++) begin
        smp    = SAMPLE_W'($urandom());
        mod_on = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0, 1: mod_v = SAMPLE_W'($urandom());
          2: mod_v = SAMPLE_W'(($urandom_range(0, 1) ? 1 : -1) * int'(MOD_LIMIT)
                               + int'($urandom_range(0, 4)) - 2);
          default: mod_v = SAMPLE_W'(int'($urandom_range(0, 5242880)) - int'(MOD_LIMIT));
        endcase
        send_mono(smp, mod_on, mod_v);
      end
    end

    drain();
    if (fails == 0) begin
      $display("stereo_pan_law_unit regression: pass");
    end else begin
      $display("stereo_pan_law_unit regression: fail");
    end
    $finish;
  end

endmodule
